// ===== rtl/core/kbd_diff_pkg.sv =====
// ----------------------------------------------------------------------------
// kbd_diff_pkg
// Types, codes and a helper function shared by the keyboard report differ.
// ----------------------------------------------------------------------------
`default_nettype none

package kbd_diff_pkg;

  // Number of usage bytes carried by one report beat.
  localparam int unsigned NumFields = 6;

  localparam logic [7:0] ErrorRollover   = 8'h01;
  localparam logic [7:0] UsageNumLock    = 8'h53;
  localparam logic [7:0] UsageCapsLock   = 8'h39;
  localparam logic [7:0] UsageScrollLock = 8'h47;

  localparam logic [2:0] KmNumLock    = 3'b001;
  localparam logic [2:0] KmCapsLock   = 3'b010;
  localparam logic [2:0] KmScrollLock = 3'b100;

  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_LED     = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RELEASE,
    ST_PRESS,
    ST_END
  } state_e;

  typedef struct packed {
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } report_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] usage;
    logic [2:0] locks;
    logic       ignored;
    logic       last;
  } event_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  idx_inc;
    logic  sel_new;
    logic  emit;
    kind_e kind;
    logic  ignored;
    logic  held_clr;
    logic  lock_toggle;
    logic  commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rollover;
    logic idx_last;
    logic cand;
    logic is_lock;
    logic held;
    logic out_free;
  } status_t;

  function automatic logic [2:0] lock_mask(input logic [7:0] usage);
    logic [2:0] m;
    m = 3'b000;
    if (usage == UsageNumLock) begin
      m = KmNumLock;
    end else if (usage == UsageCapsLock) begin
      m = KmCapsLock;
    end else if (usage == UsageScrollLock) begin
      m = KmScrollLock;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kbd_diff_dp.sv =====
// ----------------------------------------------------------------------------
// kbd_diff_dp
// Datapath: current and previous report, slot index, lock state and the
// registered event output.
// ----------------------------------------------------------------------------
`default_nettype none

module kbd_diff_dp #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire kbd_diff_pkg::report_t in_i,
  input  wire kbd_diff_pkg::cmd_t   cmd_i,
  output kbd_diff_pkg::status_t     status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output kbd_diff_pkg::event_t      out_o
);

  localparam int unsigned IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [7:0] in_keys [kbd_diff_pkg::NumFields];
  logic [7:0] now_d   [KEY_SLOTS];
  logic [7:0] now_q   [KEY_SLOTS];
  logic [7:0] prev_q  [KEY_SLOTS];

  logic [IdxW-1:0] idx_q;
  logic [2:0]      locks_q, locks_d;
  logic [2:0]      held_q, held_d;
  logic            rollover_q, rollover_d;
  logic            out_valid_q;
  kbd_diff_pkg::event_t out_q;

  logic [7:0] cand_u;
  logic [2:0] cand_m;
  logic       hit;
  logic       out_free;

  assign in_keys[0] = in_i.key_0;
  assign in_keys[1] = in_i.key_1;
  assign in_keys[2] = in_i.key_2;
  assign in_keys[3] = in_i.key_3;
  assign in_keys[4] = in_i.key_4;
  assign in_keys[5] = in_i.key_5;

  // Slots past the sixth field always read as no key.
  for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_slot
    if (k < kbd_diff_pkg::NumFields) begin : g_field
      assign now_d[k] = in_keys[k];
    end else begin : g_zero
      assign now_d[k] = 8'h00;
    end
  end

  always_comb begin
    rollover_d = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (now_d[k] == kbd_diff_pkg::ErrorRollover) begin
        rollover_d = 1'b1;
      end
    end
  end

  // Candidate usage of the current slot, looked up in the other report.
  always_comb begin
    cand_u = cmd_i.sel_new ? now_q[idx_q] : prev_q[idx_q];
    hit    = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (cmd_i.sel_new) begin
        if (prev_q[k] == cand_u) hit = 1'b1;
      end else begin
        if (now_q[k] == cand_u) hit = 1'b1;
      end
    end
  end

  assign cand_m   = kbd_diff_pkg::lock_mask(cand_u);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.rollover = rollover_q;
    status_o.idx_last = (idx_q == IdxW'(KEY_SLOTS - 1));
    status_o.cand     = (cand_u != 8'h00) && !hit;
    status_o.is_lock  = (cand_m != 3'b000);
    status_o.held     = ((held_q & cand_m) != 3'b000);
    status_o.out_free = out_free;
  end

  always_comb begin
    locks_d = locks_q;
    held_d  = held_q;
    if (cmd_i.held_clr) begin
      held_d = held_q & ~cand_m;
    end
    if (cmd_i.lock_toggle) begin
      locks_d = locks_q ^ cand_m;
      held_d  = held_q | cand_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        prev_q[k] <= 8'h00;
      end
      locks_q     <= kbd_diff_pkg::KmNumLock;
      held_q      <= 3'b000;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      rollover_q  <= 1'b0;
    end else begin
      locks_q <= locks_d;
      held_q  <= held_d;
      if (cmd_i.load) begin
        rollover_q <= rollover_d;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.commit) begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
          prev_q[k] <= now_q[k];
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        now_q[k] <= now_d[k];
      end
    end
    if (cmd_i.emit) begin
      out_q.kind <= cmd_i.kind;
      out_q.usage    <= ((cmd_i.kind == kbd_diff_pkg::KIND_RELEASE) ||
                         (cmd_i.kind == kbd_diff_pkg::KIND_PRESS)) ? cand_u : 8'h00;
      out_q.locks    <= locks_d;
      out_q.ignored  <= cmd_i.ignored;
      out_q.last     <= (cmd_i.kind == kbd_diff_pkg::KIND_END);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/kbd_diff_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbd_diff_ctrl
// Controller: sequences the release scan, the press scan and the end beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kbd_diff_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire kbd_diff_pkg::status_t status_i,
  output kbd_diff_pkg::cmd_t         cmd_o
);

  kbd_diff_pkg::state_e state_q, state_d;

  logic rel_adv;
  logic prs_need;
  logic prs_adv;

  assign rel_adv  = !status_i.cand || status_i.is_lock || status_i.out_free;
  assign prs_need = status_i.cand && (!status_i.is_lock || !status_i.held);
  assign prs_adv  = !prs_need || status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kbd_diff_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = kbd_diff_pkg::ST_CHECK;
      end
      kbd_diff_pkg::ST_CHECK: begin
        state_d = status_i.rollover ? kbd_diff_pkg::ST_END : kbd_diff_pkg::ST_RELEASE;
      end
      kbd_diff_pkg::ST_RELEASE: begin
        if (rel_adv && status_i.idx_last) state_d = kbd_diff_pkg::ST_PRESS;
      end
      kbd_diff_pkg::ST_PRESS: begin
        if (prs_adv && status_i.idx_last) state_d = kbd_diff_pkg::ST_END;
      end
      kbd_diff_pkg::ST_END: begin
        if (status_i.out_free) state_d = kbd_diff_pkg::ST_IDLE;
      end
      default: state_d = kbd_diff_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = kbd_diff_pkg::KIND_END;
    unique case (state_q)
      kbd_diff_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
        cmd_o.idx_clr = in_valid_i;
      end
      kbd_diff_pkg::ST_CHECK: begin
      end
      kbd_diff_pkg::ST_RELEASE: begin
        cmd_o.kind     = kbd_diff_pkg::KIND_RELEASE;
        cmd_o.emit     = status_i.cand && !status_i.is_lock && status_i.out_free;
        cmd_o.held_clr = status_i.cand && status_i.is_lock;
        cmd_o.idx_inc  = rel_adv && !status_i.idx_last;
        cmd_o.idx_clr  = rel_adv && status_i.idx_last;
      end
      kbd_diff_pkg::ST_PRESS: begin
        cmd_o.sel_new     = 1'b1;
        cmd_o.kind        = status_i.is_lock ? kbd_diff_pkg::KIND_LED
                                             : kbd_diff_pkg::KIND_PRESS;
        cmd_o.emit        = prs_need && status_i.out_free;
        cmd_o.lock_toggle = status_i.cand && status_i.is_lock && !status_i.held &&
                            status_i.out_free;
        cmd_o.idx_inc     = prs_adv && !status_i.idx_last;
      end
      kbd_diff_pkg::ST_END: begin
        cmd_o.kind    = kbd_diff_pkg::KIND_END;
        cmd_o.emit    = status_i.out_free;
        cmd_o.ignored = status_i.rollover;
        cmd_o.commit  = status_i.out_free && !status_i.rollover;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kbd_diff_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/keyboard_report_event_diff.sv =====
// ----------------------------------------------------------------------------
// keyboard_report_event_diff
// Turns boot keyboard reports into release, press, LED update and end beats.
// ----------------------------------------------------------------------------
// Each input beat is one report of six usage bytes. A report holding the
// rollover error code in any slot yields a single end beat with ignored set
// and changes no state. Otherwise the block walks the stored previous report
// one slot per cycle, holding on a slot while its beat waits for the output
// register, and emits a release for each usage missing from the new report,
// then walks the new report likewise and emits a press for each usage
// missing from the old one. Usage zero never makes an event. Num, Caps and
// Scroll Lock keys make no key events: a fresh press toggles the lock bit
// and emits an LED update, a release only clears the held bit. Every report
// closes with an end beat whose last flag is set; locks always shows the
// lock state after that beat. The controller steps the single shared compare
// unit across the slots; a rollover report skips both walks and goes from
// the check state straight to the end beat. A new report is taken while the
// end beat of the previous one still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_report_event_diff #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire kbd_diff_pkg::report_t in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output kbd_diff_pkg::event_t       out_o
);

  // Command and status buses between the sequencer and the datapath.
  kbd_diff_pkg::cmd_t    cmd;
  kbd_diff_pkg::status_t status;

  // The controller owns the input handshake and decides, slot by slot,
  // whether the datapath emits a beat, updates the lock state or advances.
  kbd_diff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds both reports, the lock state and the output register.
  kbd_diff_dp #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== test/keyboard_report_event_diff_test.sv =====
// ----------------------------------------------------------------------------
// keyboard_report_event_diff_test
// Self-checking bench for the keyboard report differ.
// ----------------------------------------------------------------------------
// A queue of boot keyboard reports is built up front: a directed opening
// that walks the corner cases of the report differ, then random reports that
// mostly evolve a held key set the way a real keyboard does, with rollover
// reports, empty reports, repeated usages and raw noise mixed in. A clocked
// driver feeds the reports to the block with random gaps, and a clocked
// monitor takes the event beats with random stalls. Every accepted report is
// run through a local model of the differ, and every event beat is compared
// field by field against the oldest expected beat.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_report_event_diff_test;

  localparam int KeySlots      = 6;
  // Plain random reports; rollover reports and the directed opening come on
  // top, for roughly 310 reports in all.
  localparam int RandomReports = 265;
  // Each report is a bounded walk of the slots, and the random gaps and stalls
  // of both sides are bounded too, so StallLimit quiet cycles means a hang.
  localparam int StallLimit    = 2000;
  localparam int DrainCycles   = 64;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready_o;
  kbd_diff_pkg::report_t in_data     = '0;
  logic                  out_valid_o;
  logic                  out_ready   = 1'b0;
  kbd_diff_pkg::event_t  out_o;

  keyboard_report_event_diff dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_i       (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_o      (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reports waiting to be driven, and event beats the model says must come.
  kbd_diff_pkg::report_t pending_reports[$];
  kbd_diff_pkg::event_t  expected_events[$];

  // Model state: the previous report, the lock LEDs and the lock keys held.
  logic [7:0] prev_keys [KeySlots];
  logic [2:0] lock_bits;
  logic [2:0] held_bits;

  int unsigned mismatches       = 0;
  int unsigned reports_total    = 0;
  int unsigned reports_accepted = 0;
  int unsigned rollover_reports = 0;
  int unsigned events_checked   = 0;
  int unsigned press_events     = 0;
  int unsigned release_events   = 0;
  int unsigned led_events       = 0;

  // Generator side: the key set the random part evolves from report to report.
  logic [7:0] gen_keys [KeySlots];

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Model of the differ.
  // ---------------------------------------------------------------------------
  function automatic logic [2:0] lock_bit_of(input logic [7:0] usage);
    case (usage)
      kbd_diff_pkg::UsageNumLock:    return kbd_diff_pkg::KmNumLock;
      kbd_diff_pkg::UsageCapsLock:   return kbd_diff_pkg::KmCapsLock;
      kbd_diff_pkg::UsageScrollLock: return kbd_diff_pkg::KmScrollLock;
      default:                       return 3'b000;
    endcase
  endfunction

  function automatic bit key_listed(input logic [7:0] keys [KeySlots],
                                    input logic [7:0] usage);
    for (int k = 0; k < KeySlots; k++) begin
      if (keys[k] == usage) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Every beat carries the lock state as it stands after that beat.
  function automatic void push_event(input kbd_diff_pkg::kind_e kind,
                                     input logic [7:0] code,
                                     input logic ign, input logic fin);
    kbd_diff_pkg::event_t ev;
    ev.kind    = kind;
    ev.usage   = code;
    ev.locks   = lock_bits;
    ev.ignored = ign;
    ev.last    = fin;
    expected_events.push_back(ev);
  endfunction

  function automatic void predict_report(input kbd_diff_pkg::report_t rpt);
    logic [7:0] now_keys [KeySlots];
    logic [2:0] mask;
    bit         rollover;
    now_keys[0] = rpt.key_0;
    now_keys[1] = rpt.key_1;
    now_keys[2] = rpt.key_2;
    now_keys[3] = rpt.key_3;
    now_keys[4] = rpt.key_4;
    now_keys[5] = rpt.key_5;
    rollover = 1'b0;
    for (int k = 0; k < KeySlots; k++) begin
      if (now_keys[k] == kbd_diff_pkg::ErrorRollover) rollover = 1'b1;
    end
    // A rollover report leaves every piece of state alone.
    if (rollover) begin
      push_event(kbd_diff_pkg::KIND_END, 8'h00, 1'b1, 1'b1);
      return;
    end
    // Releases first, walking the old report in slot order. A lock key that
    // goes up only drops its held bit.
    for (int k = 0; k < KeySlots; k++) begin
      if (prev_keys[k] == 8'h00 || key_listed(now_keys, prev_keys[k])) continue;
      mask = lock_bit_of(prev_keys[k]);
      if (mask != 3'b000) begin
        held_bits = held_bits & ~mask;
      end else begin
        push_event(kbd_diff_pkg::KIND_RELEASE, prev_keys[k], 1'b0, 1'b0);
      end
    end
    // Then presses in new slot order. A lock key toggles only if it was not
    // already held, which also makes a lock usage repeated in one report count
    // once.
    for (int k = 0; k < KeySlots; k++) begin
      if (now_keys[k] == 8'h00 || key_listed(prev_keys, now_keys[k])) continue;
      mask = lock_bit_of(now_keys[k]);
      if (mask != 3'b000) begin
        if ((held_bits & mask) == 3'b000) begin
          lock_bits = lock_bits ^ mask;
          held_bits = held_bits | mask;
          push_event(kbd_diff_pkg::KIND_LED, 8'h00, 1'b0, 1'b0);
        end
      end else begin
        push_event(kbd_diff_pkg::KIND_PRESS, now_keys[k], 1'b0, 1'b0);
      end
    end
    prev_keys = now_keys;
    push_event(kbd_diff_pkg::KIND_END, 8'h00, 1'b0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void queue_report(input logic [7:0] k0, input logic [7:0] k1,
                                       input logic [7:0] k2, input logic [7:0] k3,
                                       input logic [7:0] k4, input logic [7:0] k5);
    pending_reports.push_back(kbd_diff_pkg::report_t'({k0, k1, k2, k3, k4, k5}));
  endfunction

  // Usage picker weighted toward lock keys and ordinary keys, so that the
  // lock toggling logic sees plenty of traffic.
  function automatic logic [7:0] pick_usage();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      case ($urandom_range(0, 2))
        0:       return kbd_diff_pkg::UsageNumLock;
        1:       return kbd_diff_pkg::UsageCapsLock;
        default: return kbd_diff_pkg::UsageScrollLock;
      endcase
    end else if (sel < 8) begin
      return 8'($urandom_range(8'h04, 8'h65));
    end else if (sel == 8) begin
      return 8'($urandom_range(8'he0, 8'he7));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents one report per beat, with a random gap before each one.
  // A third of the time it runs with no gaps at all.
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_reports
    bit taken;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else begin
      taken = in_valid && in_ready_o;
      if (taken) begin
        predict_report(in_data);
        reports_accepted++;
      end
      // Valid holds with an unchanged payload until the beat is taken.
      if (!in_valid || taken) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reports.size() != 0) begin
          in_data  <= pending_reports.pop_front();
          in_valid <= 1'b1;
          in_gap   <= (((reports_accepted / 40) % 3) == 2) ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes event beats with a random stall after each one and checks
  // them against the model. Stalls also pause at times for long stretches.
  // ---------------------------------------------------------------------------
  int unsigned out_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin : check_events
    kbd_diff_pkg::event_t want;
    int unsigned          stall;
    bit                   taken;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      taken = out_valid_o && out_ready;
      stall = out_stall;
      if (taken) begin
        events_checked++;
        case (kbd_diff_pkg::kind_e'(out_o.kind))
          kbd_diff_pkg::KIND_PRESS:   press_events++;
          kbd_diff_pkg::KIND_RELEASE: release_events++;
          kbd_diff_pkg::KIND_LED:     led_events++;
          default:                    ;
        endcase
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind %0d usage %02h locks %03b",
                                    out_o.kind, out_o.usage, out_o.locks));
        end else begin
          want = expected_events.pop_front();
          if (out_o.kind != want.kind)
            report_mismatch($sformatf("beat %0d kind %0d, expected %0d",
                                      events_checked, out_o.kind, want.kind));
          if (out_o.usage != want.usage)
            report_mismatch($sformatf("beat %0d usage %02h, expected %02h",
                                      events_checked, out_o.usage, want.usage));
          if (out_o.locks != want.locks)
            report_mismatch($sformatf("beat %0d locks %03b, expected %03b",
                                      events_checked, out_o.locks, want.locks));
          if (out_o.ignored != want.ignored)
            report_mismatch($sformatf("beat %0d ignored %0b, expected %0b",
                                      events_checked, out_o.ignored, want.ignored));
          if (out_o.last != want.last)
            report_mismatch($sformatf("beat %0d last %0b, expected %0b",
                                      events_checked, out_o.last, want.last));
        end
        stall = (((events_checked / 60) % 3) == 1) ? 0 : $urandom_range(0, 19);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no beat moves on either side for too long.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("Timeout: no beat moved for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned           plain_reports;
    int unsigned           sel;
    int unsigned           slot;
    int unsigned           other;
    logic [7:0]            spare;
    kbd_diff_pkg::report_t rpt;

    // Model state after reset: num lock on, nothing held.
    for (int k = 0; k < KeySlots; k++) begin
      prev_keys[k] = 8'h00;
      gen_keys[k]  = 8'h00;
    end
    lock_bits = kbd_diff_pkg::KmNumLock;
    held_bits = 3'b000;

    // Directed opening. An empty report, a full one, the same keys again and
    // then in another slot order, which must give nothing but the end beat.
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    queue_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    queue_report(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04);
    // All six released in old slot order, then the top usages pressed.
    queue_report(8'hff, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00);
    // Rollover in the first slot and in the last slot.
    queue_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
    // Num lock off, then caps and scroll on while num stays held.
    queue_report(8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h53, 8'h39, 8'h47, 8'h00, 8'h00, 8'h00);
    // Lock key releases emit nothing; a fresh num press toggles again.
    queue_report(8'h00, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h53, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00);
    // A report of nothing but rollover codes while lock keys are held.
    queue_report(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // Caps lock in two slots toggles only once.
    queue_report(8'h39, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00);
    // Modifiers are plain keys; a repeated plain usage is pressed twice and
    // later released twice.
    queue_report(8'he0, 8'he7, 8'he0, 8'h02, 8'h80, 8'h7f);
    queue_report(8'h00, 8'he7, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'h47, 8'h53, 8'h39, 8'h47, 8'h53, 8'h39);
    queue_report(8'haa, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // Random part. Most reports change one to three slots of the held set,
    // as a typist would; the rest are rollovers, empty reports, reshuffled or
    // duplicated slots and raw noise. Injected rollovers do not count toward the plain
    // total since the block ignores them.
    plain_reports = 0;
    while (plain_reports < RandomReports) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        repeat ((sel < 55) ? 1 : $urandom_range(2, 3)) begin
          slot = $urandom_range(0, KeySlots - 1);
          gen_keys[slot] = ($urandom_range(0, 2) == 0) ? 8'h00 : pick_usage();
        end
      end else if (sel < 78) begin
        rpt = kbd_diff_pkg::report_t'({gen_keys[0], gen_keys[1], gen_keys[2],
                                       gen_keys[3], gen_keys[4], gen_keys[5]});
        rpt[8 * $urandom_range(0, KeySlots - 1) +: 8] = kbd_diff_pkg::ErrorRollover;
        pending_reports.push_back(rpt);
        rollover_reports++;
        continue;
      end else if (sel < 84) begin
        for (int k = 0; k < KeySlots; k++) gen_keys[k] = 8'h00;
      end else if (sel < 92) begin
        slot  = $urandom_range(0, KeySlots - 1);
        other = $urandom_range(0, KeySlots - 1);
        if ($urandom_range(0, 1) == 0) begin
          gen_keys[other] = gen_keys[slot];
        end else begin
          spare = gen_keys[slot];
          gen_keys[slot]  = gen_keys[other];
          gen_keys[other] = spare;
        end
      end else begin
        for (int k = 0; k < KeySlots; k++) gen_keys[k] = 8'($urandom_range(0, 255));
      end
      for (int k = 0; k < KeySlots; k++) begin
        if (gen_keys[k] == kbd_diff_pkg::ErrorRollover) rollover_reports++;
      end
      queue_report(gen_keys[0], gen_keys[1], gen_keys[2],
                   gen_keys[3], gen_keys[4], gen_keys[5]);
      plain_reports++;
    end
    reports_total = pending_reports.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every report is in and every expected beat has come out,
    // then give the block time to show any stray beat.
    while (reports_accepted != reports_total || expected_events.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived",
                                expected_events.size()));
    end

    $display("Run covered %0d reports (about %0d with a rollover code) and %0d event beats:",
             reports_accepted, rollover_reports, events_checked);
    $display("  %0d presses, %0d releases, %0d LED updates; %0d mismatches seen.",
             press_events, release_events, led_events, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== keyboard_report_event_diff.f =====
rtl/core/kbd_diff_pkg.sv
rtl/core/kbd_diff_dp.sv
rtl/core/kbd_diff_ctrl.sv
rtl/core/keyboard_report_event_diff.sv
test/keyboard_report_event_diff_test.sv
